### rtl/core/srt_pkg.sv
// Shared types, codes and field widths for the sorted record table.
`default_nettype none
package srt_pkg;
    localparam int KEY_W  = 16;
    localparam int STOP_W = 8;
    localparam int DUR_W  = 12;
    localparam int REC_W  = KEY_W + STOP_W + DUR_W;
    localparam int AVG_W  = 20;
    localparam int POS_W  = 4;
    localparam int ECNT_W = 5;
    localparam int FRAC_W = 8;
    localparam int OUT_W  = 48;

    typedef logic [2:0] t_req;
    localparam t_req REQ_INSERT   = 3'd0;
    localparam t_req REQ_DELETE   = 3'd1;
    localparam t_req REQ_SEARCH   = 3'd2;
    localparam t_req REQ_AVG_DUR  = 3'd3;
    localparam t_req REQ_AVG_STOP = 3'd4;
    localparam t_req REQ_SHORTEST = 3'd5;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_KEY   = 2'd1;
    localparam t_status ST_FULL  = 2'd2;
    localparam t_status ST_EMPTY = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_DECIDE, S_UP_RD, S_UP_WR,
        S_INS_WR, S_DN_RD, S_DN_WR, S_DIV, S_RESULT
    } t_state;

    typedef struct packed {
        logic start;
        logic scan_rd;
        logic scan_chk;
        logic up_init;
        logic up_rd;
        logic up_wr;
        logic ins_wr;
        logic dn_init;
        logic dn_rd;
        logic dn_wr;
        logic cnt_dec;
        logic div_start;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic up_done;
        logic dn_done;
        logic found;
        logic full;
        logic empty;
        logic is_insert;
        logic is_delete;
        logic is_avg;
        logic div_done;
        logic out_free;
    } t_sts;
endpackage
`default_nettype wire

### rtl/core/srt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module srt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### rtl/core/srt_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module srt_div #(
    parameter int DVD_W = 25,
    parameter int DVS_W = 5
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DVD_W-1:0] i_dividend,
    input  wire logic [DVS_W-1:0] i_divisor,
    output logic                  o_busy,
    output logic      [DVD_W-1:0] o_quotient
);
    localparam int CW = $clog2(DVD_W + 1);

    logic [DVS_W-1:0] r_rem, r_dvs;
    logic [DVD_W-1:0] r_quo;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic [DVS_W:0]   trial;
    logic             fits;

    assign trial = {r_rem, r_quo[DVD_W-1]};
    assign fits  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(DVD_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? DVS_W'(trial - {1'b0, r_dvs}) : DVS_W'(trial);
            r_quo <= {r_quo[DVD_W-2:0], fits};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;
endmodule
`default_nettype wire

### rtl/core/srt_dp.sv
// Datapath: record memory, scan registers, shift addressing, divider, result register.
`default_nettype none
module srt_dp #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire srt_pkg::t_cmd          i_cmd,
    output srt_pkg::t_sts               o_sts,
    input  wire logic [2:0]             i_req,
    input  wire logic [15:0]            i_key,
    input  wire logic [7:0]             i_stop,
    input  wire logic [11:0]            i_dur,
    output logic                        o_tvalid,
    input  wire logic                   i_tready,
    output logic [47:0]                 o_tdata
);
    import srt_pkg::*;

    localparam int AW    = TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int SUM_W = DUR_W + CNT_W;
    localparam int DVD_W = SUM_W + FRAC_W;

    t_req               r_req;
    logic [KEY_W-1:0]   r_key, r_min_key;
    logic [STOP_W-1:0]  r_stop;
    logic [DUR_W-1:0]   r_dur, r_min_dur;
    logic [CNT_W-1:0]   r_count, r_idx, r_fpos, r_ipos;
    logic [SUM_W-1:0]   r_sum;
    logic               r_found, r_empty;
    logic               r_out_valid;
    logic [OUT_W-1:0]   r_out_data;

    logic [CNT_W-1:0]   idx_m1, idx_p1;
    logic               we;
    logic [AW-1:0]      waddr, raddr;
    logic [REC_W-1:0]   wdata, rdata;
    logic [KEY_W-1:0]   rd_key;
    logic [STOP_W-1:0]  rd_stop;
    logic [DUR_W-1:0]   rd_dur;
    logic               div_busy;
    logic [DVD_W-1:0]   quotient;
    t_status            res_status;
    logic [POS_W-1:0]   res_pos;
    logic [KEY_W-1:0]   res_key;
    logic [AVG_W-1:0]   res_avg;
    logic               is_avg;

    assign idx_m1  = r_idx - CNT_W'(1);
    assign idx_p1  = r_idx + CNT_W'(1);
    assign rd_key  = rdata[REC_W-1 -: KEY_W];
    assign rd_stop = rdata[DUR_W +: STOP_W];
    assign rd_dur  = rdata[DUR_W-1:0];
    assign is_avg  = (r_req == REQ_AVG_DUR) || (r_req == REQ_AVG_STOP);

    always_comb begin
        raddr = r_idx[AW-1:0];
        if (i_cmd.up_rd) begin
            raddr = idx_m1[AW-1:0];
        end else if (i_cmd.dn_rd) begin
            raddr = idx_p1[AW-1:0];
        end
        we    = i_cmd.up_wr || i_cmd.dn_wr || i_cmd.ins_wr;
        waddr = i_cmd.ins_wr ? r_ipos[AW-1:0] : r_idx[AW-1:0];
        wdata = i_cmd.ins_wr ? {r_key, r_stop, r_dur} : rdata;
    end

    srt_ram #(.WIDTH(REC_W), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    srt_div #(.DVD_W(DVD_W), .DVS_W(CNT_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend ({r_sum, FRAC_W'(0)}),
        .i_divisor  (r_count),
        .o_busy     (div_busy),
        .o_quotient (quotient)
    );

    // Scan and shift bookkeeping
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_req   <= i_req;
            r_key   <= i_key;
            r_stop  <= i_stop;
            r_dur   <= i_dur;
            r_idx   <= '0;
            r_found <= 1'b0;
            r_fpos  <= '0;
            r_ipos  <= '0;
            r_sum   <= '0;
            r_empty <= (r_count == '0);
        end
        if (i_cmd.scan_chk) begin
            if (rd_key == r_key && !r_found) begin
                r_found <= 1'b1;
                r_fpos  <= r_idx;
            end
            if (rd_key < r_key) begin
                r_ipos <= r_ipos + CNT_W'(1);
            end
            r_sum <= r_sum + ((r_req == REQ_AVG_STOP) ? SUM_W'(rd_stop) : SUM_W'(rd_dur));
            if (r_idx == '0 || rd_dur < r_min_dur) begin
                r_min_dur <= rd_dur;
                r_min_key <= rd_key;
            end
            r_idx <= idx_p1;
        end
        if (i_cmd.up_init) begin
            r_idx <= r_count;
        end
        if (i_cmd.up_wr) begin
            r_idx <= idx_m1;
        end
        if (i_cmd.dn_init) begin
            r_idx <= r_fpos;
        end
        if (i_cmd.dn_wr) begin
            r_idx <= idx_p1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.ins_wr) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_cmd.cnt_dec) begin
            r_count <= r_count - CNT_W'(1);
        end
    end

    always_comb begin
        res_status = ST_OK;
        res_pos    = '0;
        res_key    = '0;
        res_avg    = '0;
        priority if (r_req == REQ_INSERT) begin
            if (r_found) begin
                res_status = ST_KEY;
            end
        end else if (r_req > REQ_SHORTEST) begin
            res_status = ST_OK;
        end else if (r_empty) begin
            res_status = ST_EMPTY;
        end else if (r_req == REQ_DELETE || r_req == REQ_SEARCH) begin
            res_status = r_found ? ST_OK : ST_KEY;
            if (r_req == REQ_SEARCH && r_found) begin
                res_pos = POS_W'(r_fpos);
            end
        end else if (is_avg) begin
            res_avg = AVG_W'(quotient);
        end else begin
            res_key = r_min_key;
        end
    end

    // Full is judged before the insert, so remember it separately
    logic r_was_full;
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_was_full <= (r_count == CNT_W'(TABLE_DEPTH));
        end
    end

    t_status final_status;
    assign final_status = (r_req == REQ_INSERT && !r_found && r_was_full) ? ST_FULL
                                                                          : res_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= {1'b0, ECNT_W'(r_count), res_avg, res_key, res_pos, final_status};
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_data;

    always_comb begin
        o_sts           = '0;
        o_sts.scan_done = (r_idx == r_count);
        o_sts.up_done   = (r_idx == r_ipos);
        o_sts.dn_done   = (idx_p1 == r_count);
        o_sts.found     = r_found;
        o_sts.full      = r_was_full;
        o_sts.empty     = r_empty;
        o_sts.is_insert = (r_req == REQ_INSERT);
        o_sts.is_delete = (r_req == REQ_DELETE);
        o_sts.is_avg    = is_avg;
        o_sts.div_done  = !div_busy;
        o_sts.out_free  = !r_out_valid || i_tready;
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");
    a_ins_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins_wr |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("insert did not grow the table");
    a_ins_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins_wr |-> !r_found && !r_was_full)
        else $error("insert write with key present or table full");
endmodule
`default_nettype wire

### rtl/core/srt_ctrl.sv
// Request sequencer: scan, shift, divide and result hand-off.
`default_nettype none
module srt_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output srt_pkg::t_cmd      o_cmd,
    input  wire srt_pkg::t_sts i_sts
);
    import srt_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_in_valid) n_state = S_SCAN_RD;
            S_SCAN_RD:  n_state = i_sts.scan_done ? S_DECIDE : S_SCAN_CHK;
            S_SCAN_CHK: n_state = S_SCAN_RD;
            S_DECIDE: begin
                priority if (i_sts.is_insert && !i_sts.found && !i_sts.full) begin
                    n_state = S_UP_RD;
                end else if (i_sts.is_delete && !i_sts.empty && i_sts.found) begin
                    n_state = S_DN_RD;
                end else if (i_sts.is_avg && !i_sts.empty) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_UP_RD:    n_state = i_sts.up_done ? S_INS_WR : S_UP_WR;
            S_UP_WR:    n_state = S_UP_RD;
            S_INS_WR:   n_state = S_RESULT;
            S_DN_RD:    n_state = i_sts.dn_done ? S_RESULT : S_DN_WR;
            S_DN_WR:    n_state = S_DN_RD;
            S_DIV:      if (i_sts.div_done) n_state = S_RESULT;
            S_RESULT:   if (i_sts.out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.start = i_in_valid;
            end
            S_SCAN_RD:  o_cmd.scan_rd  = !i_sts.scan_done;
            S_SCAN_CHK: o_cmd.scan_chk = 1'b1;
            S_DECIDE: begin
                priority if (i_sts.is_insert && !i_sts.found && !i_sts.full) begin
                    o_cmd.up_init = 1'b1;
                end else if (i_sts.is_delete && !i_sts.empty && i_sts.found) begin
                    o_cmd.dn_init = 1'b1;
                end else if (i_sts.is_avg && !i_sts.empty) begin
                    o_cmd.div_start = 1'b1;
                end else begin
                    o_cmd.start = 1'b0;
                end
            end
            S_UP_RD:    o_cmd.up_rd  = !i_sts.up_done;
            S_UP_WR:    o_cmd.up_wr  = 1'b1;
            S_INS_WR:   o_cmd.ins_wr = 1'b1;
            S_DN_RD: begin
                o_cmd.dn_rd   = !i_sts.dn_done;
                o_cmd.cnt_dec = i_sts.dn_done;
            end
            S_DN_WR:    o_cmd.dn_wr    = 1'b1;
            S_DIV:      o_cmd.start    = 1'b0;
            S_RESULT:   o_cmd.load_out = i_sts.out_free;
            default:    o_cmd.start    = 1'b0;
        endcase
    end

    a_result_leave: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESULT && i_sts.out_free) |=> r_state == S_IDLE)
        else $error("result not handed off");
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && !i_sts.div_done) |=> r_state == S_DIV)
        else $error("left divide before quotient ready");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |-> r_state == S_IDLE && o_in_ready)
        else $error("request taken outside idle");
endmodule
`default_nettype wire

### rtl/core/sorted_record_table_core.sv
// Top level of the sorted record table: sequencer plus datapath.
// Each request first scans all held records; an insert then shifts the records at and
//   after its position up, a delete shifts those after the found key down, and an
//   average waits for the divider, which forms one quotient bit per dividend bit.
// Throughput: one request at a time; the next input transfer is taken once the result
//   is in the output register.
// Reset: synchronous, active low; the table becomes empty, record memory is not cleared.
`default_nettype none
module sorted_record_table_core #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [39:0] i_s_axis_tdata,  // key[15:0], stop_count[23:16], duration[35:24]
    input  wire logic [2:0]  i_s_axis_tuser,  // req_type[2:0]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [47:0]      o_m_axis_tdata   // status[1:0], position[5:2],
                                              // result_key[21:6], average[41:22],
                                              // entry_count[46:42]
);
    import srt_pkg::*;

    t_cmd cmd;
    t_sts sts;

    srt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    srt_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .i_req    (i_s_axis_tuser),
        .i_key    (i_s_axis_tdata[15:0]),
        .i_stop   (i_s_axis_tdata[23:16]),
        .i_dur    (i_s_axis_tdata[35:24]),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata)
    );
endmodule
`default_nettype wire
